>>> src/hsc_pkg.sv
`default_nettype none

package hsc_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CNT_W  = 12;

    localparam logic [CNT_W-1:0] COUNT_MAX = 12'hFFF;
    localparam logic [CNT_W-1:0] CMP_STEP  = 12'd3;
    localparam logic [CNT_W-1:0] SWP_STEP  = 12'd1;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     is_last;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     is_final;
        logic [CNT_W-1:0]         comparison_count;
        logic [CNT_W-1:0]         swap_count;
        logic                     dropped;
    } t_out_item;

    typedef enum logic [3:0] {
        S_LOAD,
        S_BUILD,
        S_NODE_LD,
        S_SD_READ,
        S_SD_CMP1,
        S_SD_CMP2,
        S_SD_WR2,
        S_EXTRACT,
        S_EX_WR1,
        S_EX_WR2,
        S_OUT_LD,
        S_OUT_WAIT
    } t_state;

endpackage

`default_nettype wire

>>> src/heap_sort_with_counters.sv
// heap_sort_with_counters
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one signed element per
// transfer, one transfer per cycle while loading. The transfer with is_last set
// closes the run; elements beyond MAX_ELEMENTS are discarded and flagged.
// Output channel (o_out_valid / i_out_ready / o_out_data): the run's elements
// in ascending order, is_final on the last one, with the run's comparison
// count, swap count and dropped flag repeated on every transfer.
// After the closing transfer the block sorts in place. Every heap build
// step has a state of its own; every sift-down visit steps through memory
// read, two compares and second write, and the visit that ends a sift stops
// after the compares; every root/last exchange reads both cells, then writes
// them back. All of it goes through the single dual-read, single-write
// element memory. Each result is then read from memory into the output
// register; the next one is read only after the current one transfers.
// o_in_ready is high only in the load phase; the next run starts after the
// final result transfer. A stalled receiver simply holds the output register.
// Reset empties the store, clears counters and flag, and drops any run.
`default_nettype none

module heap_sort_with_counters #(
    parameter int unsigned MAX_ELEMENTS = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire hsc_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output hsc_pkg::t_out_item      o_out_data
);

    localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
    // child index width: 2*node+2 must never wrap
    localparam int unsigned IW = AW + 2;
    localparam logic [CW-1:0] CAP = CW'(MAX_ELEMENTS);

    // element store: one write port, two registered read ports
    logic signed [hsc_pkg::DATA_W-1:0] mem [MAX_ELEMENTS];
    logic                              mem_we;
    logic [AW-1:0]                     mem_wa;
    logic signed [hsc_pkg::DATA_W-1:0] mem_wd;
    logic                              rd_a_en, rd_b_en;
    logic [AW-1:0]                     rd_a_addr, rd_b_addr;
    logic signed [hsc_pkg::DATA_W-1:0] r_rda, r_rdb;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_a_en) begin
            r_rda <= mem[rd_a_addr];
        end
        if (rd_b_en) begin
            r_rdb <= mem[rd_b_addr];
        end
    end

    // control state
    hsc_pkg::t_state         r_state, n_state;
    logic [CW-1:0]           r_fill, n_fill;     // element count of the run
    logic [CW-1:0]           r_k, n_k;           // build / extract loop index
    logic [CW-1:0]           r_len, n_len;       // current heap length
    logic [CW-1:0]           r_j, n_j;           // output index
    logic                    r_phase_ex, n_phase_ex; // sift called from extract
    logic [hsc_pkg::CNT_W-1:0] r_cmp, n_cmp;
    logic [hsc_pkg::CNT_W-1:0] r_swp, n_swp;
    logic                    r_drop, n_drop;
    logic                    r_out_valid, n_out_valid;

    // sift-down datapath
    logic [AW-1:0]                     r_node, n_node;
    logic [AW-1:0]                     r_big, n_big;
    logic signed [hsc_pkg::DATA_W-1:0] r_nodev, n_nodev;  // value travelling down
    logic signed [hsc_pkg::DATA_W-1:0] r_bigv, n_bigv;
    hsc_pkg::t_out_item                r_out, n_out;

    logic [IW-1:0] lc, rc, len_ext;
    logic          lc_in, rc_in;
    logic [hsc_pkg::CNT_W-1:0] cmp_bump, swp_bump;
    logic [CW-1:0] j_inc;

    assign lc      = {1'b0, r_node, 1'b1};
    assign rc      = {1'b0, r_node, 1'b0} + IW'(2);
    assign len_ext = IW'(r_len);
    assign lc_in   = lc < len_ext;
    assign rc_in   = rc < len_ext;
    assign j_inc   = r_j + CW'(1);

    // saturating counter steps
    assign cmp_bump = (r_cmp > (hsc_pkg::COUNT_MAX - hsc_pkg::CMP_STEP)) ?
                      hsc_pkg::COUNT_MAX : r_cmp + hsc_pkg::CMP_STEP;
    assign swp_bump = (r_swp == hsc_pkg::COUNT_MAX) ?
                      hsc_pkg::COUNT_MAX : r_swp + hsc_pkg::SWP_STEP;

    assign o_in_ready  = (r_state == hsc_pkg::S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_k         = r_k;
        n_len       = r_len;
        n_j         = r_j;
        n_phase_ex  = r_phase_ex;
        n_cmp       = r_cmp;
        n_swp       = r_swp;
        n_drop      = r_drop;
        n_out_valid = r_out_valid;
        n_node      = r_node;
        n_big       = r_big;
        n_nodev     = r_nodev;
        n_bigv      = r_bigv;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_wa      = r_node;
        mem_wd      = r_nodev;
        rd_a_en     = 1'b0;
        rd_b_en     = 1'b0;
        rd_a_addr   = r_node;
        rd_b_addr   = r_node;

        case (r_state)
            hsc_pkg::S_LOAD: begin
                if (i_in_valid) begin
                    if (r_fill < CAP) begin
                        mem_we = 1'b1;
                        mem_wa = r_fill[AW-1:0];
                        mem_wd = i_in_data.value;
                        n_fill = r_fill + CW'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_in_data.is_last) begin
                        // heap build runs k = n/2 down to 1, sifting node k-1
                        n_k     = n_fill >> 1;
                        n_state = hsc_pkg::S_BUILD;
                    end
                end
            end

            hsc_pkg::S_BUILD: begin
                if (r_k != '0) begin
                    rd_a_en    = 1'b1;
                    rd_a_addr  = AW'(r_k - CW'(1));
                    n_node     = AW'(r_k - CW'(1));
                    n_len      = r_fill;
                    n_k        = r_k - CW'(1);
                    n_phase_ex = 1'b0;
                    n_state    = hsc_pkg::S_NODE_LD;
                end else begin
                    n_k     = r_fill - CW'(1);
                    n_state = hsc_pkg::S_EXTRACT;
                end
            end

            // node value arrives; first visit of this sift
            hsc_pkg::S_NODE_LD: begin
                n_nodev   = r_rda;
                rd_a_en   = 1'b1;
                rd_b_en   = 1'b1;
                rd_a_addr = lc[AW-1:0];
                rd_b_addr = rc[AW-1:0];
                n_cmp     = cmp_bump;
                n_state   = hsc_pkg::S_SD_CMP1;
            end

            // later visits: node value already held in r_nodev
            hsc_pkg::S_SD_READ: begin
                rd_a_en   = 1'b1;
                rd_b_en   = 1'b1;
                rd_a_addr = lc[AW-1:0];
                rd_b_addr = rc[AW-1:0];
                n_cmp     = cmp_bump;
                n_state   = hsc_pkg::S_SD_CMP1;
            end

            hsc_pkg::S_SD_CMP1: begin
                if (lc_in && (r_rda > r_nodev)) begin
                    n_big  = lc[AW-1:0];
                    n_bigv = r_rda;
                end else begin
                    n_big  = r_node;
                    n_bigv = r_nodev;
                end
                n_state = hsc_pkg::S_SD_CMP2;
            end

            hsc_pkg::S_SD_CMP2: begin
                if (rc_in && (r_rdb > r_bigv)) begin
                    n_big  = rc[AW-1:0];
                    n_bigv = r_rdb;
                end
                if (n_big == r_node) begin
                    // heap property holds here, sift done
                    n_state = r_phase_ex ? hsc_pkg::S_EXTRACT : hsc_pkg::S_BUILD;
                end else begin
                    // larger child moves up into the node's slot
                    mem_we  = 1'b1;
                    mem_wa  = r_node;
                    mem_wd  = n_bigv;
                    n_swp   = swp_bump;
                    n_state = hsc_pkg::S_SD_WR2;
                end
            end

            hsc_pkg::S_SD_WR2: begin
                mem_we  = 1'b1;
                mem_wa  = r_big;
                mem_wd  = r_nodev;
                n_node  = r_big;
                n_state = hsc_pkg::S_SD_READ;
            end

            hsc_pkg::S_EXTRACT: begin
                rd_a_en   = 1'b1;
                rd_a_addr = '0;
                if (r_k != '0) begin
                    rd_b_en   = 1'b1;
                    rd_b_addr = r_k[AW-1:0];
                    n_state   = hsc_pkg::S_EX_WR1;
                end else begin
                    // sorted; fetch the first result
                    n_j     = '0;
                    n_state = hsc_pkg::S_OUT_LD;
                end
            end

            // root/last exchange, then sift the new root over k elements
            hsc_pkg::S_EX_WR1: begin
                mem_we  = 1'b1;
                mem_wa  = '0;
                mem_wd  = r_rdb;
                n_nodev = r_rdb;
                n_swp   = swp_bump;
                n_state = hsc_pkg::S_EX_WR2;
            end

            hsc_pkg::S_EX_WR2: begin
                mem_we     = 1'b1;
                mem_wa     = r_k[AW-1:0];
                mem_wd     = r_rda;
                n_len      = r_k;
                n_k        = r_k - CW'(1);
                n_node     = '0;
                n_phase_ex = 1'b1;
                n_state    = hsc_pkg::S_SD_READ;
            end

            hsc_pkg::S_OUT_LD: begin
                n_out.sorted_value     = r_rda;
                n_out.is_final         = (j_inc == r_fill);
                n_out.comparison_count = r_cmp;
                n_out.swap_count       = r_swp;
                n_out.dropped          = r_drop;
                n_out_valid            = 1'b1;
                n_state                = hsc_pkg::S_OUT_WAIT;
            end

            hsc_pkg::S_OUT_WAIT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    if (r_out.is_final) begin
                        // run complete, start a fresh one
                        n_fill  = '0;
                        n_cmp   = '0;
                        n_swp   = '0;
                        n_drop  = 1'b0;
                        n_state = hsc_pkg::S_LOAD;
                    end else begin
                        rd_a_en   = 1'b1;
                        rd_a_addr = j_inc[AW-1:0];
                        n_j       = j_inc;
                        n_state   = hsc_pkg::S_OUT_LD;
                    end
                end
            end

            default: begin
                n_state = hsc_pkg::S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hsc_pkg::S_LOAD;
            r_fill      <= '0;
            r_k         <= '0;
            r_len       <= '0;
            r_j         <= '0;
            r_phase_ex  <= 1'b0;
            r_cmp       <= '0;
            r_swp       <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_k         <= n_k;
            r_len       <= n_len;
            r_j         <= n_j;
            r_phase_ex  <= n_phase_ex;
            r_cmp       <= n_cmp;
            r_swp       <= n_swp;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_node  <= n_node;
        r_big   <= n_big;
        r_nodev <= n_nodev;
        r_bigv  <= n_bigv;
        r_out   <= n_out;
    end

endmodule

`default_nettype wire

>>> bench/heap_sort_with_counters_test.sv
`default_nettype none

module heap_sort_with_counters_test;
    import hsc_pkg::*;

    localparam int CAPACITY     = 64;
    // Upper bound on the length of the whole test, enforced by the watchdog.
    localparam int CYCLE_LIMIT  = 400000;
    // Quiet cycles after the last result, long enough to catch a stray transfer.
    localparam int DRAIN_CYCLES = 60;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #5 i_clk = ~i_clk;

    // DUT ports; every input is known from time zero
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    heap_sort_with_counters #(
        .MAX_ELEMENTS(CAPACITY)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // Elements waiting to be presented, and sorted results waiting to arrive
    t_in_item  pending_elements[$];
    t_out_item predicted_sorted[$];

    // Idle / stall rates in percent, changed per phase by the stimulus block
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int fail_count  = 0;
    int cycle_count = 0;

    // ------------------------------------------------------------------
    // Sorter model: its own copy of the store, fill level and counters.
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] heap_mem [CAPACITY];
    int heap_fill     = 0;
    int cmp_total     = 0;
    int swp_total     = 0;
    bit overflow_seen = 1'b0;

    // Counters stick at the 12-bit ceiling instead of wrapping.
    function automatic int sat_add(int acc, int amount);
        return (acc + amount > int'(COUNT_MAX)) ? int'(COUNT_MAX) : acc + amount;
    endfunction

    function automatic void swap_cells(int a, int b);
        logic signed [DATA_W-1:0] t;
        t           = heap_mem[a];
        heap_mem[a] = heap_mem[b];
        heap_mem[b] = t;
    endfunction

    // One sift-down over heap_mem[0 .. heap_len-1]; every visited node costs
    // three comparisons, every exchange one swap.
    function automatic void sift_heap(int heap_len, int node);
        int big;
        int lc;
        int rc;
        bit settled;
        settled = 1'b0;
        while (!settled) begin
            big = node;
            lc  = 2 * node + 1;
            rc  = 2 * node + 2;
            cmp_total = sat_add(cmp_total, int'(CMP_STEP));
            if (lc < heap_len && heap_mem[lc] > heap_mem[big]) big = lc;
            if (rc < heap_len && heap_mem[rc] > heap_mem[big]) big = rc;
            if (big == node) begin
                settled = 1'b1;
            end else begin
                swp_total = sat_add(swp_total, int'(SWP_STEP));
                swap_cells(node, big);
                node = big;
            end
        end
    endfunction

    // Takes one accepted element. On is_last the stored set is heap sorted
    // and one result per element is queued, then the run state clears.
    function automatic void absorb_element(t_in_item item);
        int k;
        t_out_item r;
        if (heap_fill < CAPACITY) begin
            heap_mem[heap_fill] = item.value;
            heap_fill++;
        end else begin
            overflow_seen = 1'b1;  // beyond capacity: value discarded
        end
        if (!item.is_last) return;

        for (k = heap_fill / 2; k > 0; k--) sift_heap(heap_fill, k - 1);
        for (k = heap_fill - 1; k > 0; k--) begin
            swp_total = sat_add(swp_total, int'(SWP_STEP));
            swap_cells(0, k);
            sift_heap(k, 0);
        end

        for (k = 0; k < heap_fill; k++) begin
            r.sorted_value     = heap_mem[k];
            r.is_final         = (k + 1 == heap_fill);
            r.comparison_count = cmp_total[CNT_W-1:0];
            r.swap_count       = swp_total[CNT_W-1:0];
            r.dropped          = overflow_seen;
            predicted_sorted.push_back(r);
        end

        heap_fill     = 0;
        cmp_total     = 0;
        swp_total     = 0;
        overflow_seen = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued elements, holds valid and payload until the
    // transfer, and may idle between transfers. The model sees each element
    // at the edge where it transfers.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) absorb_element(i_in_data);
            // Free to change the payload only when nothing is on offer or
            // the current element just transferred.
            if (!i_in_valid || o_in_ready) begin
                if (pending_elements.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    i_in_data  <= pending_elements.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every result transfer is checked field by field against the
    // oldest prediction. Ready is redrawn each cycle.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (predicted_sorted.size() == 0) begin
                    $error("unexpected result: sorted_value %0d", o_out_data.sorted_value);
                    fail_count++;
                end else begin
                    want = predicted_sorted.pop_front();
                    if (o_out_data.sorted_value !== want.sorted_value) begin
                        $error("sorted_value: expected %0d, got %0d",
                               want.sorted_value, o_out_data.sorted_value);
                        fail_count++;
                    end
                    if (o_out_data.is_final !== want.is_final) begin
                        $error("is_final: expected %0d, got %0d",
                               want.is_final, o_out_data.is_final);
                        fail_count++;
                    end
                    if (o_out_data.comparison_count !== want.comparison_count) begin
                        $error("comparison_count: expected %0d, got %0d",
                               want.comparison_count, o_out_data.comparison_count);
                        fail_count++;
                    end
                    if (o_out_data.swap_count !== want.swap_count) begin
                        $error("swap_count: expected %0d, got %0d",
                               want.swap_count, o_out_data.swap_count);
                        fail_count++;
                    end
                    if (o_out_data.dropped !== want.dropped) begin
                        $error("dropped: expected %0d, got %0d",
                               want.dropped, o_out_data.dropped);
                        fail_count++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** heap_sort_with_counters: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_element(logic signed [DATA_W-1:0] v, bit last);
        t_in_item item;
        item.value   = v;
        item.is_last = last;
        pending_elements.push_back(item);
    endtask

    // Mostly full-range values, some narrow ones for duplicates, some extremes.
    function automatic logic signed [DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5) return $urandom;
        if (sel < 8) return $signed($urandom_range(16)) - 8;
        case ($urandom_range(4))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return 0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    // One run of n transfers; the last one carries is_last.
    task automatic queue_run(int n);
        int k;
        for (k = 0; k < n; k++) push_element(pick_value(), k == n - 1);
    endtask

    // Sampled at the falling edge so the check never races the driver.
    task automatic wait_drained();
        while (pending_elements.size() > 0 || i_in_valid || predicted_sorted.size() > 0)
            @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int phase;
        int phase_items;
        int n;
        int idle_tab[4];
        int stall_tab[4];

        // phases: no idling, sender idle, receiver stall, both
        idle_tab  = '{0, 67, 0, 31};
        stall_tab = '{0, 0, 67, 31};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: single-element runs at both extremes (no comparisons,
        // no swaps), a mixed-extremes run, equal pair, descending positives, descending negatives.
        push_element(VAL_MAX, 1'b1);
        push_element(VAL_MIN, 1'b1);
        push_element(VAL_MAX, 1'b0);
        push_element(VAL_MIN, 1'b0);
        push_element(0, 1'b0);
        push_element(-1, 1'b0);
        push_element(1, 1'b0);
        push_element(VAL_MAX, 1'b0);
        push_element(VAL_MIN, 1'b1);
        push_element(5, 1'b0);
        push_element(5, 1'b1);
        for (n = 8; n >= 1; n--) push_element(n, n == 1);
        for (n = 1; n <= 6; n++) push_element(-n * 1000, n == 6);
        wait_drained();

        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct  = idle_tab[phase];
            recv_stall_pct = stall_tab[phase];
            phase_items    = 0;
            // One run past capacity: the closing transfer is itself dropped
            // yet still starts the sort. Later a run that fills the store.
            if (phase == 1) begin
                queue_run(CAPACITY + 1);
            end
            if (phase == 3) begin
                queue_run(CAPACITY);
            end
            while (phase_items < 4) begin
                n = $urandom_range(8, 1);
                queue_run(n);
                phase_items += n;
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && predicted_sorted.size() == 0) begin
            $display("** heap_sort_with_counters: PASSED **");
        end else begin
            $display("** heap_sort_with_counters: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
